/* rtl/bat_pkg.sv */
// ----------------------------------------------------------------------------
// bat_pkg: shared types and constants of the breakpoint address table
// sizes, request and result codes, and the records passed between the units
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int ADDR_WIDTH  = 32;

	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

	// field widths of one beat
	localparam int ACT_W     = 2;
	localparam int IN_ADDR_W = 32;
	localparam int EIDX_W    = 8;
	localparam int STAT_W    = 2;
	localparam int NUM_W     = 5;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 8;

	localparam logic [EIDX_W-1:0] NUM_ENTRIES_B = EIDX_W'(NUM_ENTRIES);

	typedef logic [ADDR_WIDTH-1:0] addr_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [NUM_W-1:0]      num_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD     = 2'd0,
		ACT_ENABLE  = 2'd1,
		ACT_DISABLE = 2'd2,
		ACT_LOOKUP  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		action_t             action;
		addr_t               address;
		logic [EIDX_W-1:0]   entry_index;
	} cmd_t;

	typedef struct packed {
		logic    we;
		idx_t    waddr;
		addr_t   wdata;
		idx_t    raddr;
	} mem_req_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		num_t    num;
	} result_t;

	// keep the low address bits, or zero-extend
	function automatic addr_t to_addr(input logic [IN_ADDR_W-1:0] a);
		logic [63:0] w;
		w = {32'b0, a};
		return w[ADDR_WIDTH-1:0];
	endfunction

	// entry number as reported, modulo 32
	function automatic num_t to_num(input idx_t k);
		logic [7:0] w;
		w = 8'(k);
		return w[NUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/bat_entry_mem.sv */
// ----------------------------------------------------------------------------
// bat_entry_mem: stored breakpoint addresses
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module bat_entry_mem (
	input  wire logic              clk,
	input  wire bat_pkg::mem_req_t req,
	output bat_pkg::addr_t         rdata
);

	bat_pkg::addr_t mem [bat_pkg::NUM_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

/* rtl/bat_ctrl.sv */
// ----------------------------------------------------------------------------
// bat_ctrl: request sequencer of the breakpoint address table
// fill count, enable marks and the lookup scan over the address memory
// ----------------------------------------------------------------------------
`default_nettype none

module bat_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire bat_pkg::cmd_t     cmd,
	output logic                   cmd_ready,
	output bat_pkg::mem_req_t      mem_req,
	input  wire bat_pkg::addr_t    mem_rdata,
	output bat_pkg::result_t       res,
	input  wire logic              out_free
);

	localparam bat_pkg::idx_t LAST_IDX = bat_pkg::IDX_W'(bat_pkg::NUM_ENTRIES - 1);
	localparam bat_pkg::cnt_t FULL_CNT = bat_pkg::CNT_W'(bat_pkg::NUM_ENTRIES);

	bat_pkg::state_t state_q, state_d;
	bat_pkg::cmd_t   cmd_q;
	bat_pkg::cnt_t   fill_q;
	logic [bat_pkg::NUM_ENTRIES-1:0] en_q;
	bat_pkg::idx_t   scan_q;
	logic            vld_s1;
	bat_pkg::idx_t   idx_s1;
	bat_pkg::status_t res_st_q;
	bat_pkg::num_t   res_num_q;

	logic            accept;
	logic            commit;
	logic            hit;
	logic            scan_end;
	logic            full;
	logic            out_range;
	bat_pkg::addr_t  stored;

	assign accept = cmd_valid && cmd_ready;
	assign commit = res.valid && out_free;

	// entries beyond the fill count were never written and read as zero
	assign stored    = (bat_pkg::CNT_W'(idx_s1) < fill_q) ? mem_rdata : '0;
	assign hit       = vld_s1 && en_q[idx_s1] && (stored == cmd_q.address);
	assign scan_end  = vld_s1 && (hit || (idx_s1 == LAST_IDX));
	assign full      = (fill_q == FULL_CNT);
	assign out_range = (cmd_q.entry_index >= bat_pkg::NUM_ENTRIES_B);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bat_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (cmd.action == bat_pkg::ACT_LOOKUP) ? bat_pkg::S_SCAN
					                                               : bat_pkg::S_DONE;
				end
			end
			bat_pkg::S_SCAN: begin
				if (scan_end) state_d = bat_pkg::S_DONE;
			end
			bat_pkg::S_DONE: begin
				if (commit) state_d = bat_pkg::S_IDLE;
			end
			default: state_d = bat_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready     = 1'b0;
		res.valid     = 1'b0;
		res.status    = bat_pkg::ST_OK;
		res.num       = '0;
		mem_req.we    = 1'b0;
		mem_req.waddr = fill_q[bat_pkg::IDX_W-1:0];
		mem_req.wdata = cmd_q.address;
		mem_req.raddr = scan_q;
		case (state_q)
			bat_pkg::S_IDLE: cmd_ready = 1'b1;
			bat_pkg::S_SCAN: ;
			bat_pkg::S_DONE: begin
				res.valid = 1'b1;
				case (cmd_q.action)
					bat_pkg::ACT_ADD: begin
						if (full) begin
							res.status = bat_pkg::ST_FULL;
						end else begin
							res.num    = bat_pkg::to_num(fill_q[bat_pkg::IDX_W-1:0]);
							mem_req.we = out_free;
						end
					end
					bat_pkg::ACT_ENABLE, bat_pkg::ACT_DISABLE: begin
						if (out_range) begin
							res.status = bat_pkg::ST_RANGE;
						end else begin
							res.num = cmd_q.entry_index[bat_pkg::NUM_W-1:0];
						end
					end
					bat_pkg::ACT_LOOKUP: begin
						res.status = res_st_q;
						res.num    = res_num_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bat_pkg::S_IDLE;
			fill_q  <= '0;
			en_q    <= '0;
			vld_s1  <= 1'b0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			// one read issued per scan cycle, compared in the cycle after it
			vld_s1  <= (state_q == bat_pkg::S_SCAN) && !scan_end;
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == bat_pkg::S_SCAN) begin
				scan_q <= scan_q + bat_pkg::IDX_W'(1);
			end
			if (commit) begin
				case (cmd_q.action)
					bat_pkg::ACT_ADD: begin
						if (!full) begin
							en_q[fill_q[bat_pkg::IDX_W-1:0]] <= 1'b1;
							fill_q <= fill_q + bat_pkg::CNT_W'(1);
						end
					end
					bat_pkg::ACT_ENABLE: begin
						if (!out_range) en_q[cmd_q.entry_index[bat_pkg::IDX_W-1:0]] <= 1'b1;
					end
					bat_pkg::ACT_DISABLE: begin
						if (!out_range) en_q[cmd_q.entry_index[bat_pkg::IDX_W-1:0]] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd_q <= cmd;
		idx_s1 <= scan_q;
		if (scan_end) begin
			res_st_q  <= hit ? bat_pkg::ST_OK : bat_pkg::ST_NOMATCH;
			res_num_q <= hit ? bat_pkg::to_num(idx_s1) : '0;
		end
	end

endmodule

`default_nettype wire

/* rtl/breakpoint_address_table_unit.sv */
// an add, enable or disable goes from idle to the done state, and its result is then
//   taken into the output register once that is free; a lookup first steps the scan,
//   which reads one stored address per cycle from the entry memory and stops at the first match
// one request at a time: the next beat is taken once the result is in the output register
// reset: arst_n clears the fill count and every enable mark at once, no clearing pass
// ----------------------------------------------------------------------------
// breakpoint_address_table_unit: breakpoint address match table
// adds, enables, disables and looks up breakpoint entries held in a small memory
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_address_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request beat
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action[1:0], address[33:2], entry_index[41:34], zero pad
	input  wire logic [bat_pkg::S_DATA_W-1:0] s_tdata,
	// result beat
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[1:0], entry_number[6:2], zero pad
	output logic [bat_pkg::M_DATA_W-1:0] m_tdata
);

	bat_pkg::cmd_t     cmd;
	bat_pkg::mem_req_t mem_req;
	bat_pkg::addr_t    mem_rdata;
	bat_pkg::result_t  res;
	logic              out_free;
	bat_pkg::status_t  status_q;
	bat_pkg::num_t     num_q;
	logic              m_tvalid_q;

	// unpack the request beat
	assign cmd.action      = bat_pkg::action_t'(s_tdata[1:0]);
	assign cmd.address     = bat_pkg::to_addr(s_tdata[33:2]);
	assign cmd.entry_index = s_tdata[41:34];

	// output register is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	bat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd       (cmd),
		.cmd_ready (s_tready),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res       (res),
		.out_free  (out_free)
	);

	// addresses only; the enable marks and fill count live in the sequencer
	bat_entry_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			status_q <= res.status;
			num_q    <= res.num;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, num_q, status_q};

endmodule

`default_nettype wire

/* rtl/bat_checker.sv */
// ----------------------------------------------------------------------------
// bat_checker: port-level checks of the breakpoint address table
// watches the request and result beats only
// ----------------------------------------------------------------------------
`default_nettype none

module bat_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [bat_pkg::S_DATA_W-1:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [bat_pkg::M_DATA_W-1:0] m_tdata
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	// one request in flight: no beat taken right after one
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while one is in flight");

	// entry number is zero unless status is ok
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != bat_pkg::ST_OK) |-> m_tdata[6:2] == 5'd0)
		else $error("entry number set on failed request");

	// no result shows at the edge right after a request is taken
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind breakpoint_address_table_unit bat_checker u_bat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
